/* rtl/dbks_pkg.sv */
// Shared types and constants for the depth bucket key sorter.
package dbks_pkg;

    localparam int KEY_W    = 64;
    localparam int BUCKET_W = 16;
    localparam int DIST_W   = 32;

    typedef struct packed {
        logic [1:0]  item_lane;
        logic [31:0] distance;
        logic [19:0] material_id;
        logic [23:0] mesh_id;
        logic [3:0]  lod;
        logic [15:0] item_handle;
        logic        last_item;
    } dbks_in_t;

    typedef struct packed {
        logic [15:0] out_handle;
        logic [19:0] out_material;
        logic [23:0] out_mesh;
        logic [3:0]  out_lod;
        logic [15:0] depth_bucket;
        logic        last_result;
        logic        overflowed;
    } dbks_out_t;

    // One sort entry as it moves through the chain.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [15:0]      handle;
    } dbks_ent_t;

endpackage

/* rtl/depth_bucket_key_sorter.sv */
// Top level of the depth bucket key sorter.
// Loads one lane of draw items, one transfer per cycle, into per-field RAMs while
// tracking nearest and farthest distance. On the item carrying last_item
// the block stops taking input if any item was stored, then for each
// stored item reads it back (address state, then divider start), computes
// its depth bucket with a bit-serial divider (skipped, giving bucket 0,
// when the span is flat) and inserts the packed key into a chain of
// MAX_ITEMS sort cells. After the last insertion the chain shifts its head
// out one entry per accepted output transfer; payload fields of the head
// are looked up in the RAMs and registered before each result is offered.
module depth_bucket_key_sorter
    import dbks_pkg::*;
#(
    parameter int MAX_ITEMS      = 64,
    parameter int DEPTH_BUCKETS  = 64,
    parameter int DIST_FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  dbks_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output dbks_out_t out_data
);
    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CW    = AW + 1;
    localparam int TW    = $clog2(DEPTH_BUCKETS);
    localparam int NUM_W = DIST_W + TW;
    localparam logic [TW-1:0] TOP = TW'(DEPTH_BUCKETS - 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_ORD  = 3'd4;
    localparam logic [2:0] S_ORW  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_GO   = 3'd7;

    logic [2:0]        st_reg, st_next;
    logic [1:0]        lane_reg;
    logic [DIST_W-1:0] near_reg, far_reg;
    logic [CW-1:0]     cnt_reg, idx_reg, left_reg;
    logic              ovf_reg, flat_reg;
    logic [AW-1:0]     raddr;

    logic [DIST_W-1:0] r_dist;
    logic [19:0]       r_mat;
    logic [23:0]       r_mesh;
    logic [3:0]        r_lod;
    logic [15:0]       r_hnd;
    logic [15:0]       bucket_reg;
    dbks_out_t         out_reg;
    logic              ov_reg;

    // Load side.
    logic in_xfer, match, store;
    assign in_stall = (st_reg != S_LOAD);
    assign in_xfer  = in_valid && !in_stall;
    assign match    = (in_data.item_lane == lane_reg);
    assign store    = in_xfer && match && (cnt_reg < CW'(MAX_ITEMS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_reg <= '0;
        else if (cfg_we)
            lane_reg <= cfg_wdata;
    end

    // Storage, one RAM per field.
    logic [AW-1:0] waddr;
    assign waddr = cnt_reg[AW-1:0];

    dbks_ram #(.WIDTH(DIST_W), .DEPTH(MAX_ITEMS)) u_dist (.clk, .we(store),
        .waddr, .wdata(in_data.distance), .raddr, .rdata(r_dist));
    dbks_ram #(.WIDTH(20), .DEPTH(MAX_ITEMS)) u_mat (.clk, .we(store),
        .waddr, .wdata(in_data.material_id), .raddr, .rdata(r_mat));
    dbks_ram #(.WIDTH(24), .DEPTH(MAX_ITEMS)) u_mesh (.clk, .we(store),
        .waddr, .wdata(in_data.mesh_id), .raddr, .rdata(r_mesh));
    dbks_ram #(.WIDTH(4), .DEPTH(MAX_ITEMS)) u_lod (.clk, .we(store),
        .waddr, .wdata(in_data.lod), .raddr, .rdata(r_lod));
    dbks_ram #(.WIDTH(16), .DEPTH(MAX_ITEMS)) u_hnd (.clk, .we(store),
        .waddr, .wdata(in_data.item_handle), .raddr, .rdata(r_hnd));

    // Divider: (d - near) * top / span.
    // Started in the cycle after the read address settles, so r_dist is current.
    logic [DIST_W-1:0] span, doff;
    logic [NUM_W-1:0]  quo;
    logic              div_start, div_done;
    assign span      = far_reg - near_reg;
    assign doff      = r_dist - near_reg;
    assign div_start = (st_reg == S_GO) && !flat_reg;

    dbks_div #(.NUM_W(NUM_W), .DEN_W(DIST_W)) u_div (.clk, .rst_n,
        .start(div_start), .num(NUM_W'(doff) * NUM_W'(TOP)), .den(span),
        .done(div_done), .quo);

    logic [15:0] bucket_calc;
    always_comb
    begin
        if (flat_reg)
            bucket_calc = '0;
        else if (quo > NUM_W'(TOP))
            bucket_calc = 16'(TOP);
        else
            bucket_calc = 16'(quo);
    end

    // Sort chain: key plus storage index in the handle slot.
    logic      ins, shift, chain_clear;
    dbks_ent_t new_ent;
    logic      full  [MAX_ITEMS];
    logic      takes [MAX_ITEMS];
    dbks_ent_t ent   [MAX_ITEMS];

    assign ins         = (st_reg == S_INS);
    assign new_ent.key = {bucket_reg, r_mat, r_mesh, r_lod};
    assign new_ent.handle = 16'(idx_reg);

    // The head cell sees a full neighbor in front, so it fills first.
    for (genvar g = 0; g < MAX_ITEMS; g++)
    begin : g_cell
        dbks_cell u_cell (
            .clk, .rst_n, .clear(chain_clear), .ins, .new_ent,
            .prev_full (g == 0 ? 1'b1 : full[(g == 0) ? 0 : g-1]),
            .prev_takes(g == 0 ? 1'b0 : takes[(g == 0) ? 0 : g-1]),
            .prev_ent  (ent[(g == 0) ? 0 : g-1]),
            .shift,
            .next_full (g == MAX_ITEMS-1 ? 1'b0 : full[(g == MAX_ITEMS-1) ? g : g+1]),
            .next_ent  (ent[(g == MAX_ITEMS-1) ? g : g+1]),
            .full(full[g]), .takes(takes[g]), .ent(ent[g]));
    end

    logic out_xfer;
    assign out_valid = (st_reg == S_OUT);
    assign out_xfer  = out_valid && !out_stall;
    assign shift     = (st_reg == S_ORD);
    assign chain_clear = 1'b0;

    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        if (st_reg == S_ORD)
            raddr = ent[0].handle[AW-1:0];
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_LOAD: if (in_xfer && in_data.last_item)
                        st_next = ((cnt_reg != '0) || store) ? S_RD : S_LOAD;
            S_RD:   st_next = S_GO;
            S_GO:   st_next = S_DIV;
            S_DIV:  if (flat_reg || div_done) st_next = S_INS;
            S_INS:  st_next = (idx_reg + 1'b1 == cnt_reg) ? S_ORD : S_RD;
            S_ORD:  st_next = S_ORW;
            S_ORW:  st_next = S_OUT;
            S_OUT:  if (out_xfer)
                        st_next = (left_reg == CW'(1)) ? S_LOAD : S_ORD;
            default: st_next = S_LOAD;
        endcase
    end

    // Bucket per storage slot so the drain can report it.
    logic [15:0] bkt_rd;
    dbks_ram #(.WIDTH(16), .DEPTH(MAX_ITEMS)) u_bkt (.clk, .we(ins),
        .waddr(idx_reg[AW-1:0]), .wdata(bucket_reg), .raddr, .rdata(bkt_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_LOAD;
            near_reg <= '0;
            far_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            flat_reg <= 1'b0;
            idx_reg  <= '0;
            left_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (store)
            begin
                if (cnt_reg == '0 || in_data.distance < near_reg)
                    near_reg <= in_data.distance;
                if (cnt_reg == '0 || in_data.distance > far_reg)
                    far_reg <= in_data.distance;
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (in_xfer && match)
                ovf_reg <= 1'b1;
            if (st_reg == S_LOAD && st_next == S_RD)
            begin
                idx_reg <= '0;
                // Capacity flag from this transfer counts too.
                ov_reg  <= ovf_reg || (in_xfer && match && !store);
            end
            if (st_reg == S_RD)
                flat_reg <= ({32'd0, span} * 64'd10000) <=
                            (64'd1 << DIST_FRAC_BITS);
            if (st_reg == S_INS)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (st_next == S_ORD)
                    left_reg <= cnt_reg;
            end
            if (out_xfer)
            begin
                left_reg <= left_reg - 1'b1;
                if (left_reg == CW'(1))
                begin
                    cnt_reg  <= '0;
                    near_reg <= '0;
                    far_reg  <= '0;
                    ovf_reg  <= 1'b0;
                    flat_reg <= 1'b0;
                end
            end
            else if (st_reg == S_LOAD && in_xfer && in_data.last_item &&
                     st_next == S_LOAD)
            begin
                cnt_reg  <= '0;
                near_reg <= '0;
                far_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_DIV)
            bucket_reg <= bucket_calc;
        if (st_reg == S_ORW)
        begin
            out_reg.out_handle   <= r_hnd;
            out_reg.out_material <= r_mat;
            out_reg.out_mesh     <= r_mesh;
            out_reg.out_lod      <= r_lod;
            out_reg.depth_bucket <= bkt_rd;
            out_reg.last_result  <= (left_reg == CW'(1));
            out_reg.overflowed   <= ov_reg;
        end
    end

    assign out_data = out_reg;

    // Input is held off for the whole sort and drain.
    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_LOAD) |-> in_stall)
        else $error("input taken outside load");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && out_data.last_result) |=> (st_reg == S_LOAD))
        else $error("drain did not end on last result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ITEMS))
        else $error("item count over capacity");
endmodule

/* rtl/dbks_div.sv */
// Restoring divider, one quotient bit per cycle.
module dbks_div
    import dbks_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]   sh;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, d_reg})
            begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = sh;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= den;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

/* rtl/dbks_cell.sv */
// One cell of the insertion sorting chain.
module dbks_cell
    import dbks_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clear,
    input  logic      ins,
    input  dbks_ent_t new_ent,
    input  logic      prev_full,
    input  logic      prev_takes,
    input  dbks_ent_t prev_ent,
    input  logic      shift,
    input  logic      next_full,
    input  dbks_ent_t next_ent,
    output logic      full,
    output logic      takes,
    output dbks_ent_t ent
);
    logic      full_reg, full_next;
    dbks_ent_t ent_reg, ent_next;

    // New key goes in ahead of any strictly greater key; ties stay behind.
    // An empty cell only takes when it sits right behind the last full one.
    assign takes = ins && (full_reg ? (ent_reg.key > new_ent.key) : prev_full);

    always_comb
    begin
        full_next = full_reg;
        ent_next  = ent_reg;
        if (clear)
            full_next = 1'b0;
        else if (shift)
        begin
            full_next = next_full;
            ent_next  = next_ent;
        end
        else if (takes)
        begin
            full_next = 1'b1;
            ent_next  = (prev_takes && prev_full) ? prev_ent : new_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
        ent_reg <= ent_next;

    assign full = full_reg;
    assign ent  = ent_reg;
endmodule

/* rtl/dbks_ram.sv */
// Generic single-port-write, registered-read RAM.
module dbks_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
